/* rtl/c3ldc_pkg.sv */
// Shared types and constants for the 3x3 convolution core.
// Used by the front, queue, back and top-level modules; depends on nothing else.
package c3ldc_pkg;

	// Clamp ceiling of a result pixel.
	localparam logic [7:0] PIX_MAX = 8'd255;

	// Reset values of the geometry registers.
	localparam logic [10:0] WIDTH_RST  = 11'd512;
	localparam logic [11:0] HEIGHT_RST = 12'd512;

	// Depth of the queue between front and back, and its pointer width.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEF_LEFT   = 3'd0,
		REG_COEF_CENTRE = 3'd1,
		REG_COEF_RIGHT  = 3'd2,
		REG_WIDTH       = 3'd3,
		REG_HEIGHT      = 3'd4
	} cfg_reg_t;

	// Input item.
	typedef struct packed {
		logic [7:0] pixel;
		logic       frame_start;
	} pix_t;

	// Result item.
	typedef struct packed {
		logic [7:0] filtered;
		logic       frame_end;
	} res_t;

	// Queue entry: one pixel with its column from the two previous rows.
	typedef struct packed {
		logic [7:0] pixel;
		logic [7:0] above;
		logic [7:0] mid;
		logic       emit;
		logic       frame_end;
	} qent_t;

	// Coefficient registers, one per column offset.
	typedef struct packed {
		logic [23:0] left;
		logic [23:0] centre;
		logic [23:0] right;
	} coef_t;

	// Frame geometry registers as written.
	typedef struct packed {
		logic [10:0] width;
		logic [11:0] height;
	} geom_t;

endpackage

/* rtl/c3ldc_front.sv */
// Front part: position tracking, border classification and the line store.
// Depends on c3ldc_pkg; feeds c3ldc_fifo.
module c3ldc_front #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pix_valid,
	output logic                pix_stall,
	input  c3ldc_pkg::pix_t     pix_data,
	input  c3ldc_pkg::geom_t    geom,
	output logic                q_valid,
	input  logic                q_ready,
	output c3ldc_pkg::qent_t    q_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = CW + 1;

	logic [CW-1:0] col_q;
	logic [11:0]   row_q;

	logic [WW-1:0] w_eff;
	logic [11:0]   h_eff;
	logic [CW-1:0] c0, c1;
	logic [11:0]   r0, r2;
	logic [12:0]   r1, r_inc;
	logic [WW-1:0] c_inc;
	logic          emit, fend;

	logic          s1_valid_q;
	logic [7:0]    pixel_s1;
	logic [CW-1:0] col_s1;
	logic          emit_s1, fend_s1;
	logic          fwd_s1;
	logic [7:0]    fwd_above_s1, fwd_mid_s1;
	logic [15:0]   rd_s1;
	logic [7:0]    above_res, mid_res;

	// Each word holds the row before last in the high byte, the last row in the low byte.
	logic [15:0]   line_mem [MAX_WIDTH];

	logic accept, push;

	assign push      = s1_valid_q && q_ready;
	assign pix_stall = s1_valid_q && !q_ready;
	assign accept    = pix_valid && !pix_stall;

	// Effective frame size after range limiting.
	always_comb begin
		if (geom.width < 11'd3) begin
			w_eff = WW'(3);
		end else if (32'(geom.width) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(geom.width);
		end
		h_eff = (geom.height < 12'd3) ? 12'd3 : geom.height;
	end

	// Position of the incoming pixel and whether it completes an interior window.
	always_comb begin
		c0 = pix_data.frame_start ? '0 : col_q;
		r0 = pix_data.frame_start ? '0 : row_q;
		if (WW'(c0) >= w_eff) begin
			c1 = '0;
			r1 = 13'(r0) + 13'd1;
		end else begin
			c1 = c0;
			r1 = 13'(r0);
		end
		r2    = (r1 >= 13'(h_eff)) ? 12'd0 : r1[11:0];
		c_inc = WW'(c1) + WW'(1);
		r_inc = 13'(r2) + 13'd1;
		emit  = (r2 >= 12'd2) && (c1 >= CW'(2));
		fend  = (13'(r2) == 13'(h_eff) - 13'd1) && (WW'(c1) == w_eff - WW'(1));
	end

	// Position counters and stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				if (c_inc >= w_eff) begin
					col_q <= '0;
					row_q <= (r_inc >= 13'(h_eff)) ? 12'd0 : r_inc[11:0];
				end else begin
					col_q <= c_inc[CW-1:0];
					row_q <= r2;
				end
				s1_valid_q <= 1'b1;
			end else if (push) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	// The store is stale when the item ahead writes the same column this cycle.
	assign above_res = fwd_s1 ? fwd_above_s1 : rd_s1[15:8];
	assign mid_res   = fwd_s1 ? fwd_mid_s1   : rd_s1[7:0];

	// Stage payload, forwarding capture, and line store read and write.
	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_s1     <= pix_data.pixel;
			col_s1       <= c1;
			emit_s1      <= emit;
			fend_s1      <= fend;
			fwd_s1       <= push && (col_s1 == c1);
			fwd_above_s1 <= mid_res;
			fwd_mid_s1   <= pixel_s1;
			rd_s1        <= line_mem[c1];
		end
		if (push) begin
			line_mem[col_s1] <= {mid_res, pixel_s1};
		end
	end

	assign q_valid          = s1_valid_q;
	assign q_data.pixel     = pixel_s1;
	assign q_data.above     = above_res;
	assign q_data.mid       = mid_res;
	assign q_data.emit      = emit_s1;
	assign q_data.frame_end = fend_s1;

	// An accepted pixel always lands inside the effective row.
	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (WW'(col_s1) < w_eff))
		else $error("front: column beyond effective width");

	// A frame start always restarts at column zero.
	a_start_col: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && pix_data.frame_start) |=> (col_s1 == '0) && !emit_s1)
		else $error("front: frame start not at column zero");

endmodule

/* rtl/c3ldc_fifo.sv */
// Short queue between the front and back parts of the convolution core.
// Depends on c3ldc_pkg for the entry type and depth.
module c3ldc_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  c3ldc_pkg::qent_t  push_data,
	output logic              pop_valid,
	input  logic              pop_ready,
	output c3ldc_pkg::qent_t  pop_data
);

	localparam int PW = c3ldc_pkg::QPTR_W;

	c3ldc_pkg::qent_t entries [c3ldc_pkg::QDEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [PW:0]      count_q;
	logic             push, pop;

	assign push_ready = (count_q != (PW+1)'(c3ldc_pkg::QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = entries[rd_ptr_q];

	// Pointer and fill count bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(c3ldc_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(c3ldc_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PW+1)'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entries[wr_ptr_q] <= push_data;
		end
	end

	// The fill count never exceeds the depth.
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PW+1)'(c3ldc_pkg::QDEPTH))
		else $error("fifo: fill count above depth");

	// A lone push grows the count by exactly one.
	a_count_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + (PW+1)'(1)))
		else $error("fifo: fill count did not follow a push");

endmodule

/* rtl/c3ldc_back.sv */
// Back part: 3x3 window, coefficient products, sum and clamp, output register.
// Depends on c3ldc_pkg; drains c3ldc_fifo.
module c3ldc_back #(
	parameter int COEF_BITS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  c3ldc_pkg::coef_t  coef,
	input  logic              q_valid,
	output logic              q_ready,
	input  c3ldc_pkg::qent_t  q_data,
	output logic              res_valid,
	input  logic              res_stall,
	output c3ldc_pkg::res_t   res_data
);

	localparam int CU = (COEF_BITS < 8) ? COEF_BITS : 8;

	logic [7:0]         win_q [9];
	logic [7:0]         win_n [9];
	logic [23:0]        creg  [3];
	logic signed [7:0]  cf    [9];

	logic signed [16:0] prod_s1 [9];
	logic               valid_s1, fend_s1;
	logic signed [18:0] part_s2 [3];
	logic               valid_s2, fend_s2;
	logic signed [20:0] total;
	logic [7:0]         clamped;

	logic               res_valid_q;
	c3ldc_pkg::res_t    res_q;
	logic               adv, pop;

	// The whole back part moves unless a finished result is held.
	assign adv     = !res_valid_q || !res_stall;
	assign q_ready = adv;
	assign pop     = adv && q_valid;

	assign creg[0] = coef.left;
	assign creg[1] = coef.centre;
	assign creg[2] = coef.right;

	// Shifted window, indexed column times three plus row.
	always_comb begin
		for (int k = 0; k < 6; k++) begin
			win_n[k] = win_q[k+3];
		end
		win_n[6] = q_data.above;
		win_n[7] = q_data.mid;
		win_n[8] = q_data.pixel;
	end

	// Coefficients: low CU bits of each byte slot, sign extended.
	always_comb begin
		logic signed [CU-1:0] cs;
		cs = '0;
		for (int col = 0; col < 3; col++) begin
			for (int row = 0; row < 3; row++) begin
				cs = signed'(creg[col][8*row +: CU]);
				cf[col*3+row] = 8'(cs);
			end
		end
	end

	// Final sum of the three row sums and clamp to the pixel range.
	always_comb begin
		total = 21'(part_s2[0]) + 21'(part_s2[1]) + 21'(part_s2[2]);
		if (total > 21'sd255) begin
			clamped = c3ldc_pkg::PIX_MAX;
		end else if (total < 21'sd0) begin
			clamped = 8'd0;
		end else begin
			clamped = total[7:0];
		end
	end

	// Window contents and stage valids.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 9; k++) begin
				win_q[k] <= 8'd0;
			end
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (adv) begin
			if (pop) begin
				for (int k = 0; k < 9; k++) begin
					win_q[k] <= win_n[k];
				end
			end
			valid_s1    <= pop && q_data.emit;
			valid_s2    <= valid_s1;
			res_valid_q <= valid_s2;
		end
	end

	// Products, row sums and the result payload.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 9; k++) begin
				prod_s1[k] <= signed'({1'b0, win_n[k]}) * cf[k];
			end
			fend_s1 <= q_data.frame_end;
			for (int row = 0; row < 3; row++) begin
				part_s2[row] <= 19'(prod_s1[row]) + 19'(prod_s1[3+row]) + 19'(prod_s1[6+row]);
			end
			fend_s2            <= fend_s1;
			res_q.filtered     <= clamped;
			res_q.frame_end    <= fend_s2;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	// A new result appears only after a summed interior item.
	a_res_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(valid_s2))
		else $error("back: result without a summed item");

endmodule

/* rtl/conv3x3_line_detect_clamp_core.sv */
// Top level of the 3x3 convolution core: configuration registers and the
// front, queue and back parts. Depends on c3ldc_pkg and the c3ldc_* modules.
//
// Usage:
//   The pixel channel (pix_valid, pix_stall, pix_data) takes one 8-bit pixel
//   per item in row order; frame_start marks row 0, column 0 of a frame.
//   The result channel (res_valid, res_stall, res_data) gives one clamped
//   sum for each interior pixel, on the item that brings the pixel below and
//   right of the window centre; frame_end flags the last one of a frame.
//   Border pixels produce no result.
//   The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
//   always ready; write it only while no item is in flight.
// Throughput and path:
//   One pixel per cycle sustained while pix_stall is low. A pixel passes
//   through the line store read, queue, product stage and row sum stage,
//   then its result is clamped into the output register.
// Reset and stalls:
//   Reset clears position, window, queue and valids; coefficients go to zero
//   and the size to 512 by 512. The line store is not cleared. When the
//   receiver stalls the result holds, the back part freezes, the queue fills
//   and then pix_stall rises.
module conv3x3_line_detect_clamp_core #(
	parameter int MAX_WIDTH = 1024,
	parameter int COEF_BITS = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 pix_valid,
	output logic                                 pix_stall,
	input  c3ldc_pkg::pix_t                      pix_data,
	output logic                                 res_valid,
	input  logic                                 res_stall,
	output c3ldc_pkg::res_t                      res_data,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [c3ldc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [23:0]                          cfg_data
);

	c3ldc_pkg::coef_t  coef_q;
	c3ldc_pkg::geom_t  geom_q;
	c3ldc_pkg::qent_t  fq_data, qb_data;
	logic              fq_valid, fq_ready, qb_valid, qb_ready;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.left   <= '0;
			coef_q.centre <= '0;
			coef_q.right  <= '0;
			geom_q.width  <= c3ldc_pkg::WIDTH_RST;
			geom_q.height <= c3ldc_pkg::HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (c3ldc_pkg::cfg_reg_t'(cfg_index))
				c3ldc_pkg::REG_COEF_LEFT:   coef_q.left   <= cfg_data;
				c3ldc_pkg::REG_COEF_CENTRE: coef_q.centre <= cfg_data;
				c3ldc_pkg::REG_COEF_RIGHT:  coef_q.right  <= cfg_data;
				c3ldc_pkg::REG_WIDTH:       geom_q.width  <= cfg_data[10:0];
				c3ldc_pkg::REG_HEIGHT:      geom_q.height <= cfg_data[11:0];
				default: begin
				end
			endcase
		end
	end

	c3ldc_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix_data  (pix_data),
		.geom      (geom_q),
		.q_valid   (fq_valid),
		.q_ready   (fq_ready),
		.q_data    (fq_data)
	);

	c3ldc_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_data  (fq_data),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_data   (qb_data)
	);

	c3ldc_back #(
		.COEF_BITS (COEF_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.coef      (coef_q),
		.q_valid   (qb_valid),
		.q_ready   (qb_ready),
		.q_data    (qb_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

endmodule
